>>> rtl/core/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types, constants and helpers for the text cursor glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

   localparam int GLYPH_ROWS = 8;
   localparam int ROW_W      = 3;

   localparam logic [15:0] CUR_MAX   = 16'hFFFF;
   localparam logic [15:0] GLYPH_ADV = 16'd8;
   localparam logic [15:0] TAB_STEP  = 16'd64;

   // input operations
   localparam logic OP_TEXT = 1'b0;
   localparam logic OP_FONT = 1'b1;

   // result kinds
   localparam logic KIND_ROW   = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   // control bytes
   localparam logic [7:0] CODE_WHITE   = 8'd1;
   localparam logic [7:0] CODE_RED     = 8'd2;
   localparam logic [7:0] CODE_GREEN   = 8'd3;
   localparam logic [7:0] CODE_BLUE    = 8'd4;
   localparam logic [7:0] CODE_YELLOW  = 8'd5;
   localparam logic [7:0] CODE_MAGENTA = 8'd6;
   localparam logic [7:0] CODE_CYAN    = 8'd7;
   localparam logic [7:0] CODE_TAB     = 8'd9;
   localparam logic [7:0] CODE_NEWLINE = 8'd10;

   // register indexes
   localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
   localparam logic [1:0] REG_SCALE_FACTOR  = 2'd2;

   localparam int CSR_ADDR_W = 4;

   localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd1024;
   localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd768;
   localparam logic [3:0]  RST_SCALE_FACTOR  = 4'd2;

   localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;

   typedef struct packed {
      logic [12:0] screen_width;
      logic [12:0] screen_height;
      logic [3:0]  scale_factor;
   } tcgr_cfg_type;

   typedef struct packed {
      logic accept;
      logic check;
      logic load_clear;
      logic load_row;
   } tcgr_cmd_type;

   typedef struct packed {
      logic printable;
      logic clear_hit;
      logic out_free;
      logic row_last;
   } tcgr_status_type;

   function automatic logic [23:0] palette_color(input logic [7:0] code);
      logic [23:0] color;
      case (code)
         CODE_RED:     color = 24'hFF0000;
         CODE_GREEN:   color = 24'h00FF00;
         CODE_BLUE:    color = 24'h0000FF;
         CODE_YELLOW:  color = 24'hFFFF00;
         CODE_MAGENTA: color = 24'hFF00FF;
         CODE_CYAN:    color = 24'h00FFFF;
         default:      color = COLOR_WHITE;
      endcase
      return color;
   endfunction

   function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? CUR_MAX : s[15:0];
   endfunction

   function automatic logic [15:0] sat_scale(input logic [16:0] v, input logic [3:0] scale);
      logic [20:0] p;
      p = {4'b0, v} * {17'b0, scale};
      return (p > {5'b0, CUR_MAX}) ? CUR_MAX : p[15:0];
   endfunction

endpackage

>>> rtl/core/tcgr_req_if.sv
// ----------------------------------------------------------------------------
// tcgr_req_if
// Input channel: text bytes and font row loads.
// ----------------------------------------------------------------------------
interface tcgr_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] code;
   logic [2:0] font_row;
   logic [7:0] font_bits;

   modport source (output valid, output op, output code, output font_row,
                   output font_bits, input ready);
   modport sink   (input valid, input op, input code, input font_row,
                   input font_bits, output ready);
endinterface

>>> rtl/core/tcgr_rsp_if.sv
// ----------------------------------------------------------------------------
// tcgr_rsp_if
// Result channel: glyph rows and clear markers.
// ----------------------------------------------------------------------------
interface tcgr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] pixel_x;
   logic [15:0] pixel_y;
   logic [7:0]  row_bits;
   logic [7:0]  red;
   logic [7:0]  green;
   logic [7:0]  blue;
   logic        last;

   modport source (output valid, output kind, output pixel_x, output pixel_y,
                   output row_bits, output red, output green, output blue,
                   output last, input ready);
   modport sink   (input valid, input kind, input pixel_x, input pixel_y,
                   input row_bits, input red, input green, input blue,
                   input last, output ready);
endinterface

>>> rtl/core/tcgr_csr.sv
// ----------------------------------------------------------------------------
// tcgr_csr
// APB-style register file: screen width, screen height and scale factor.
// ----------------------------------------------------------------------------
module tcgr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tcgr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready,
   output tcgr_pkg::tcgr_cfg_type            cfg
);
   import tcgr_pkg::*;

   tcgr_cfg_type cfg_ff;
   tcgr_cfg_type cfg_in;
   logic [1:0]   index;
   logic         wr_en;

   assign index      = csr_paddr[3:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_SCREEN_WIDTH:  cfg_in.screen_width  = csr_pwdata[12:0];
            REG_SCREEN_HEIGHT: cfg_in.screen_height = csr_pwdata[12:0];
            REG_SCALE_FACTOR:  cfg_in.scale_factor  = csr_pwdata[3:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_SCREEN_WIDTH:  csr_prdata = {19'b0, cfg_ff.screen_width};
         REG_SCREEN_HEIGHT: csr_prdata = {19'b0, cfg_ff.screen_height};
         REG_SCALE_FACTOR:  csr_prdata = {28'b0, cfg_ff.scale_factor};
         default:           csr_prdata = 32'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.screen_width  <= RST_SCREEN_WIDTH;
         cfg_ff.screen_height <= RST_SCREEN_HEIGHT;
         cfg_ff.scale_factor  <= RST_SCALE_FACTOR;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

>>> rtl/core/tcgr_ctrl.sv
// ----------------------------------------------------------------------------
// tcgr_ctrl
// Sequencer: accepts an item; a printable byte gets the clear test, then the
// clear marker on a hit and the eight glyph rows go to the output register.
// ----------------------------------------------------------------------------
module tcgr_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tcgr_pkg::tcgr_status_type  status,
   output tcgr_pkg::tcgr_cmd_type     cmd
);
   import tcgr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_CLEAR,
      ST_ROWS
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.printable) state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.clear_hit ? ST_CLEAR : ST_ROWS;
         end
         ST_CLEAR: begin
            if (status.out_free) begin
               cmd.load_clear = 1'b1;
               state_in       = ST_ROWS;
            end
         end
         ST_ROWS: begin
            if (status.out_free) begin
               cmd.load_row = 1'b1;
               if (status.row_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/core/tcgr_dp.sv
// ----------------------------------------------------------------------------
// tcgr_dp
// Datapath: cursor and color registers, font memory, coordinate scaling and
// the result output register.
// ----------------------------------------------------------------------------
module tcgr_dp #(
   parameter int FONT_CHARS = 128,
   parameter int LINE_PITCH = 12
) (
   input  logic                       clock,
   input  logic                       reset,
   input  tcgr_pkg::tcgr_cfg_type     cfg,
   input  tcgr_pkg::tcgr_cmd_type     cmd,
   output tcgr_pkg::tcgr_status_type  status,
   input  logic                       req_op,
   input  logic [7:0]                 req_code,
   input  logic [2:0]                 req_font_row,
   input  logic [7:0]                 req_font_bits,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_kind,
   output logic [15:0]                rsp_pixel_x,
   output logic [15:0]                rsp_pixel_y,
   output logic [7:0]                 rsp_row_bits,
   output logic [7:0]                 rsp_red,
   output logic [7:0]                 rsp_green,
   output logic [7:0]                 rsp_blue,
   output logic                       rsp_last
);
   import tcgr_pkg::*;

   localparam int DEPTH  = FONT_CHARS * GLYPH_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CODE_W = ADDR_W - ROW_W;

   logic [7:0]  font_mem [DEPTH];
   logic [7:0]  rd_ff;

   logic [15:0] cx_ff, cx_in;
   logic [15:0] cy_ff, cy_in;
   logic [23:0] color_ff, color_in;
   logic [7:0]  code_ff, code_in;
   logic [2:0]  row_ff, row_in;

   logic        out_valid_ff;
   logic        out_kind_ff;
   logic [15:0] out_px_ff;
   logic [15:0] out_py_ff;
   logic [7:0]  out_bits_ff;
   logic [23:0] out_color_ff;
   logic        out_last_ff;

   logic [20:0] wrap_prod;
   logic [20:0] clear_prod;
   logic        wrap_hit;
   logic        text_op;
   logic        printable;
   logic        in_range;
   logic        font_we;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   // Line wrap and clear tests: v*scale > limit-1 is v*scale >= limit,
   // which also covers a limit of zero.
   assign wrap_prod  = {4'b0, {1'b0, cx_ff} + 17'd8} * {17'b0, cfg.scale_factor};
   assign clear_prod = {4'b0, {1'b0, cy_ff} + 17'd8} * {17'b0, cfg.scale_factor};
   assign wrap_hit   = wrap_prod >= {8'b0, cfg.screen_width};

   assign text_op   = (req_op == OP_TEXT);
   assign printable = text_op && !req_code[7]
                      && !((req_code >= CODE_WHITE) && (req_code <= CODE_CYAN))
                      && (req_code != CODE_TAB) && (req_code != CODE_NEWLINE);
   assign in_range  = {1'b0, code_ff} < 9'(FONT_CHARS);

   assign status.printable = printable;
   assign status.clear_hit = clear_prod >= {8'b0, cfg.screen_height};
   assign status.out_free  = !out_valid_ff || rsp_ready;
   assign status.row_last  = (row_ff == 3'(GLYPH_ROWS - 1));

   // font memory: one write port, one registered read port
   assign font_we = cmd.accept && (req_op == OP_FONT)
                    && ({1'b0, req_code} < 9'(FONT_CHARS));
   assign wr_addr = {req_code[CODE_W-1:0], req_font_row};
   // read the row the counter will hold next cycle, so data lines up with row_ff
   assign rd_addr = {code_in[CODE_W-1:0], row_in};

   always_ff @(posedge clock) begin
      if (font_we) font_mem[wr_addr] <= req_font_bits;
   end

   always_ff @(posedge clock) begin
      rd_ff <= font_mem[rd_addr];
   end

   always_comb begin
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      color_in = color_ff;
      code_in  = code_ff;
      row_in   = row_ff;

      if (cmd.accept && text_op) begin
         if (req_code[7]) begin
            cx_in = sat_add16(cx_ff, GLYPH_ADV);
         end else begin
            case (req_code)
               CODE_NEWLINE: begin
                  color_in = COLOR_WHITE;
                  cx_in    = '0;
                  cy_in    = sat_add16(cy_ff, 16'(LINE_PITCH));
               end
               CODE_TAB: begin
                  cx_in = sat_add16(cx_ff, TAB_STEP);
               end
               CODE_WHITE: begin
                  color_in = COLOR_WHITE;
               end
               CODE_RED, CODE_GREEN, CODE_BLUE, CODE_YELLOW, CODE_MAGENTA, CODE_CYAN: begin
                  color_in = palette_color(req_code);
               end
               default: begin
                  code_in = req_code;
                  row_in  = '0;
                  if (wrap_hit) begin
                     cx_in = '0;
                     cy_in = sat_add16(cy_ff, 16'(LINE_PITCH));
                  end
               end
            endcase
         end
      end

      if (cmd.check && status.clear_hit) begin
         cx_in = '0;
         cy_in = '0;
      end

      if (cmd.load_row) begin
         row_in = row_ff + 3'd1;
         if (status.row_last) cx_in = sat_add16(cx_ff, GLYPH_ADV);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff    <= '0;
         cy_ff    <= '0;
         color_ff <= COLOR_WHITE;
         row_ff   <= '0;
      end else begin
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         color_ff <= color_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_clear || cmd.load_row) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_clear) begin
         out_kind_ff  <= KIND_CLEAR;
         out_px_ff    <= '0;
         out_py_ff    <= '0;
         out_bits_ff  <= '0;
         out_color_ff <= '0;
         out_last_ff  <= 1'b0;
      end else if (cmd.load_row) begin
         out_kind_ff  <= KIND_ROW;
         out_px_ff    <= sat_scale({1'b0, cx_ff} + 17'd1, cfg.scale_factor);
         out_py_ff    <= sat_scale({1'b0, cy_ff} + {14'b0, row_ff}, cfg.scale_factor);
         out_bits_ff  <= in_range ? rd_ff : 8'b0;
         out_color_ff <= color_ff;
         out_last_ff  <= status.row_last;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_kind     = out_kind_ff;
   assign rsp_pixel_x  = out_px_ff;
   assign rsp_pixel_y  = out_py_ff;
   assign rsp_row_bits = out_bits_ff;
   assign rsp_red      = out_color_ff[23:16];
   assign rsp_green    = out_color_ff[15:8];
   assign rsp_blue     = out_color_ff[7:0];
   assign rsp_last     = out_last_ff;

endmodule

>>> rtl/core/text_cursor_glyph_renderer.sv
// ----------------------------------------------------------------------------
// text_cursor_glyph_renderer
// Text-mode renderer with an 8x8 font, a text cursor and a drawing color.
// ----------------------------------------------------------------------------
// Font loads and control bytes (cursor moves, color selects) give no result.
// A printable byte is accepted (line wrap applied there), gets the screen-
// bottom test, then yields one glyph row per cycle for eight rows while the
// output side keeps up, paced by the single registered read port of the font
// memory; a clear marker comes first on a screen-bottom hit. Results leave
// through a one-deep output register, so the next item is accepted while the
// final row still waits to be taken. The user must write configuration via
// the APB-style port only while the block is idle; the block does not enforce it.
module text_cursor_glyph_renderer #(
   parameter int FONT_CHARS = 128,
   parameter int LINE_PITCH = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   tcgr_req_if.sink                         req_port,
   tcgr_rsp_if.source                       rsp_port,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tcgr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import tcgr_pkg::*;

   tcgr_cfg_type    cfg;
   tcgr_cmd_type    cmd;
   tcgr_status_type status;
   logic            req_ready;

   assign req_port.ready = req_ready;

   tcgr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tcgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcgr_dp #(
      .FONT_CHARS (FONT_CHARS),
      .LINE_PITCH (LINE_PITCH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .status        (status),
      .req_op        (req_port.op),
      .req_code      (req_port.code),
      .req_font_row  (req_port.font_row),
      .req_font_bits (req_port.font_bits),
      .rsp_valid     (rsp_port.valid),
      .rsp_ready     (rsp_port.ready),
      .rsp_kind      (rsp_port.kind),
      .rsp_pixel_x   (rsp_port.pixel_x),
      .rsp_pixel_y   (rsp_port.pixel_y),
      .rsp_row_bits  (rsp_port.row_bits),
      .rsp_red       (rsp_port.red),
      .rsp_green     (rsp_port.green),
      .rsp_blue      (rsp_port.blue),
      .rsp_last      (rsp_port.last)
   );

endmodule
